### hdl/rlx_pkg.sv
// Shared types and constants for the luxury subtract-with-borrow generator.
package rlx_pkg;

   localparam int NUM_WORDS   = 24;
   localparam int WORD_W      = 24;
   localparam int IDX_W       = 5;
   localparam int FRAC_W      = 48;
   localparam int SKIP_W      = 11;
   localparam int SHORT_LAG   = 10;
   localparam int LONG_LAG    = 14;
   localparam logic [10:0] SKIP_RESET = 11'd199;

   localparam logic [1:0] FUNC_DRAW       = 2'd0;
   localparam logic [1:0] FUNC_LOAD_WORD  = 2'd1;
   localparam logic [1:0] FUNC_LOAD_STATE = 2'd2;
   localparam logic [1:0] FUNC_NOP        = 2'd3;

   typedef enum logic [1:0] {
      CMD_DRAW,
      CMD_LOAD_WORD,
      CMD_LOAD_STATE,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      index_ok;
      logic [IDX_W-1:0]          word_index;
      logic [WORD_W-1:0]         word_value;
      logic                      carry;
      logic [IDX_W-1:0]          pos;
      logic [IDX_W-1:0]          count;
   } cmd_type;

endpackage

### hdl/rlx_if.sv
// Handshake channel interfaces for requests and responses.
interface rlx_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [4:0]  word_index;
   logic [23:0] word_value;
   logic        carry_in;
   logic [4:0]  pos_in;
   logic [4:0]  count_in;

   modport source (output valid, func, word_index, word_value, carry_in, pos_in, count_in,
                   input ready);
   modport sink (input valid, func, word_index, word_value, carry_in, pos_in, count_in,
                 output ready);
endinterface

interface rlx_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_number;
   logic [23:0] raw_word;
   logic [47:0] fraction;

   modport source (output valid, is_number, raw_word, fraction, input ready);
   modport sink (input valid, is_number, raw_word, fraction, output ready);
endinterface

### hdl/rlx_front.sv
// Request front end: accepts transactions and decodes them into commands.
module rlx_front (
   rlx_req_if.sink          req,
   input  logic             queue_full,
   output logic             push,
   output rlx_pkg::cmd_type push_cmd
);
   import rlx_pkg::*;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      push_cmd            = '0;
      push_cmd.word_index = req.word_index;
      push_cmd.word_value = req.word_value;
      push_cmd.carry      = req.carry_in;
      push_cmd.index_ok   = (req.word_index < IDX_W'(NUM_WORDS));
      push_cmd.pos        = (req.pos_in > IDX_W'(NUM_WORDS)) ? IDX_W'(NUM_WORDS) : req.pos_in;
      push_cmd.count      = (req.count_in > IDX_W'(NUM_WORDS)) ? IDX_W'(NUM_WORDS)
                                                               : req.count_in;
      case (req.func)
         FUNC_DRAW:       push_cmd.kind = CMD_DRAW;
         FUNC_LOAD_WORD:  push_cmd.kind = CMD_LOAD_WORD;
         FUNC_LOAD_STATE: push_cmd.kind = CMD_LOAD_STATE;
         default:         push_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

### hdl/rlx_cmd_queue.sv
// Two-entry command queue between front end and execution engine.
module rlx_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rlx_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output rlx_pkg::cmd_type head
);
   import rlx_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

### hdl/rlx_back.sv
// Execution engine: lag word memory, generation sequencer and result register.
module rlx_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rlx_pkg::SKIP_W-1:0] skip_count,
   input  logic                       cmd_valid,
   input  rlx_pkg::cmd_type           cmd,
   output logic                       cmd_pop,
   rlx_rsp_if.source                  rsp
);
   import rlx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEN,
      ST_DRAIN,
      ST_READ,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [WORD_W-1:0] mem [NUM_WORDS];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;
   logic [IDX_W-1:0]  rd_a_addr;
   logic [IDX_W-1:0]  rd_b_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic [IDX_W-1:0]  step_ff;
   logic [11:0]       rem_ff;
   logic              borrow_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic [IDX_W-1:0]  count_ff;
   logic              pw_vld_ff;
   logic [IDX_W-1:0]  pw_addr_ff;

   logic              res_num_ff;
   logic [WORD_W-1:0] res_raw_ff;
   logic [FRAC_W-1:0] res_frac_ff;
   logic              out_valid_ff;
   logic              out_num_ff;
   logic [WORD_W-1:0] out_raw_ff;
   logic [FRAC_W-1:0] out_frac_ff;

   logic [IDX_W-1:0]  gen_dst;
   logic [IDX_W-1:0]  gen_src;
   logic [IDX_W-1:0]  draw_idx;
   logic [IDX_W-1:0]  draw_nbr;
   logic [WORD_W:0]   diff;
   logic [11:0]       skip_span;
   logic [WORD_W-1:0] small_x;
   logic [FRAC_W-1:0] frac_val;
   logic              out_free;

   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign out_free = !out_valid_ff || rsp.ready;

   assign gen_dst  = IDX_W'(NUM_WORDS - 1) - step_ff;
   assign gen_src  = (step_ff < IDX_W'(SHORT_LAG)) ? gen_dst - IDX_W'(LONG_LAG)
                                                   : gen_dst + IDX_W'(SHORT_LAG);
   assign draw_idx = pos_ff - IDX_W'(1);
   assign draw_nbr = (draw_idx < IDX_W'(LONG_LAG)) ? draw_idx + IDX_W'(SHORT_LAG)
                                                  : draw_idx - IDX_W'(LONG_LAG);
   assign diff      = {1'b0, rd_a_ff} - {1'b0, rd_b_ff} - {{WORD_W{1'b0}}, borrow_ff};
   assign skip_span = 12'(skip_count) + 12'(NUM_WORDS) - 12'(pos_ff);

   assign small_x  = {rd_a_ff[11:0], rd_b_ff[23:12]};
   always_comb begin
      if (rd_a_ff >= WORD_W'(4096)) begin
         frac_val = {rd_a_ff, {WORD_W{1'b0}}};
      end else if (small_x == '0) begin
         frac_val = FRAC_W'(1);
      end else begin
         frac_val = {12'd0, small_x, 12'd0};
      end
   end

   always_comb begin
      rd_a_addr = gen_src;
      rd_b_addr = gen_dst;
      if (state_ff == ST_READ) begin
         rd_a_addr = draw_idx;
         rd_b_addr = draw_nbr;
      end
      wr_en   = pw_vld_ff;
      wr_addr = pw_addr_ff;
      wr_data = diff[WORD_W-1:0];
      if (!pw_vld_ff) begin
         wr_en   = cmd_pop && (cmd.kind == CMD_LOAD_WORD) && cmd.index_ok;
         wr_addr = cmd.word_index;
         wr_data = cmd.word_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.is_number = out_num_ff;
   assign rsp.raw_word  = out_raw_ff;
   assign rsp.fraction  = out_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rem_ff       <= '0;
         borrow_ff    <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         pw_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pw_vld_ff <= (state_ff == ST_GEN);
         if (pw_vld_ff) begin
            borrow_ff <= diff[WORD_W];
         end
         if (out_valid_ff && rsp.ready && (state_ff != ST_EMIT)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               res_num_ff  <= 1'b0;
               res_raw_ff  <= '0;
               res_frac_ff <= '0;
               if (cmd_valid) begin
                  case (cmd.kind)
                     CMD_DRAW: begin
                        step_ff <= '0;
                        if (count_ff >= IDX_W'(NUM_WORDS)) begin
                           count_ff <= '0;
                           if (skip_span >= 12'(NUM_WORDS)) begin
                              rem_ff   <= skip_span;
                              state_ff <= ST_GEN;
                           end else begin
                              pos_ff   <= IDX_W'(12'(NUM_WORDS) - skip_span);
                              state_ff <= ST_READ;
                           end
                        end else if (pos_ff == '0) begin
                           rem_ff   <= 12'(NUM_WORDS);
                           state_ff <= ST_GEN;
                        end else begin
                           state_ff <= ST_READ;
                        end
                     end
                     CMD_LOAD_STATE: begin
                        borrow_ff <= cmd.carry;
                        pos_ff    <= cmd.pos;
                        count_ff  <= cmd.count;
                        state_ff  <= ST_EMIT;
                     end
                     default: begin
                        state_ff <= ST_EMIT;
                     end
                  endcase
               end
            end
            ST_GEN: begin
               pw_addr_ff <= gen_dst;
               if (step_ff == IDX_W'(NUM_WORDS - 1)) begin
                  step_ff <= '0;
                  if (rem_ff >= 12'(2 * NUM_WORDS)) begin
                     rem_ff <= rem_ff - 12'(NUM_WORDS);
                  end else begin
                     pos_ff   <= IDX_W'(12'(2 * NUM_WORDS) - rem_ff);
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  step_ff <= step_ff + IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_READ;
            end
            ST_READ: begin
               pos_ff   <= draw_idx;
               count_ff <= count_ff + IDX_W'(1);
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               res_num_ff  <= 1'b1;
               res_raw_ff  <= rd_a_ff;
               res_frac_ff <= frac_val;
               state_ff    <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_num_ff   <= res_num_ff;
                  out_raw_ff   <= res_raw_ff;
                  out_frac_ff  <= res_frac_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/ranlux_luxury_generator_unit.sv
// Top level of the 24-bit luxury subtract-with-borrow generator.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    func, word_index, word_value, carry_in, pos_in, count_in
//   rsp      out        valid/ready    is_number, raw_word, fraction
//   csr      in         csr_wr_en      csr_wr_data (skip_count)
//
// From the queue head a draw passes through the read, fetch and emit states. When lag words
// are regenerated it first passes through the generate state, one block of lag words at a
// time at one word update per cycle through the single write port of the lag memory, and
// then a drain state. Loads go straight to the emit state. A transaction is queued first.
// Reset is synchronous; the lag words are not cleared and must be loaded before use.
// A two-entry command queue and the response register let either side stall alone.
module ranlux_luxury_generator_unit (
   input  logic                       clock,
   input  logic                       reset,
   rlx_req_if.sink                    req_bus,
   rlx_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [rlx_pkg::SKIP_W-1:0] csr_wr_data
);
   import rlx_pkg::*;

   logic [SKIP_W-1:0] skip_ff;
   logic              push;
   cmd_type           push_cmd;
   logic              queue_full;
   logic              pop;
   logic              not_empty;
   cmd_type           head;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= SKIP_RESET;
      end else if (csr_wr_en) begin
         skip_ff <= csr_wr_data;
      end
   end

   rlx_front u_front (
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   rlx_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   rlx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .skip_count (skip_ff),
      .cmd_valid  (not_empty),
      .cmd        (head),
      .cmd_pop    (pop),
      .rsp        (rsp_bus)
   );

endmodule
